### rtl/rtdf_pkg.sv
// ----------------------------------------------------------------------------
// rtdf_pkg: shared types and constants for the repeated trigram finder
// Field widths, count limits and the link record passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdf_pkg;

  localparam int BYTE_W     = 8;
  localparam int TRI_W      = 3 * BYTE_W;
  localparam int COUNT_W    = 32;
  localparam int MASK_W     = 64;
  localparam int WINDOW_DEF = 64;
  localparam int MIN_BYTES  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [TRI_W-1:0]   gram_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MASK_W-1:0]  mask_t;

  // One trigram plus a flag that it lies wholly within the current text
  typedef struct packed {
    logic  valid;
    gram_t gram;
  } link_t;

endpackage

`default_nettype wire

### rtl/rtdf_head.sv
// ----------------------------------------------------------------------------
// rtdf_head: front end of the trigram row
// Holds the two previous bytes and the saturating byte count of the text,
// and forms the trigram that ends at the incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdf_head (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   shift,
  input  wire rtdf_pkg::byte_t  text_byte,
  input  wire                   new_text,
  output rtdf_pkg::link_t       cur,
  output rtdf_pkg::count_t      start
);

  rtdf_pkg::byte_t  h0;
  rtdf_pkg::byte_t  h1;
  rtdf_pkg::count_t seen;
  rtdf_pkg::count_t seen_next;

  // saturating count including this beat
  always_comb begin
    if (new_text) begin
      seen_next = rtdf_pkg::COUNT_W'(1);
    end else if (seen == rtdf_pkg::COUNT_MAX) begin
      seen_next = rtdf_pkg::COUNT_MAX;
    end else begin
      seen_next = seen + rtdf_pkg::COUNT_W'(1);
    end
  end

  // current trigram and its start index; all zero for a short text
  always_comb begin
    cur.valid = (seen_next >= rtdf_pkg::COUNT_W'(rtdf_pkg::MIN_BYTES));
    cur.gram  = '0;
    start     = '0;
    if (cur.valid) begin
      cur.gram = {h1, h0, text_byte};
      if (seen_next == rtdf_pkg::COUNT_MAX) begin
        start = rtdf_pkg::COUNT_MAX;
      end else begin
        start = seen_next - rtdf_pkg::COUNT_W'(rtdf_pkg::MIN_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (shift) begin
      seen <= seen_next;
    end
  end

  // byte history needs no reset: only read once the count covers it
  always_ff @(posedge clk) begin
    if (shift) begin
      h1 <= h0;
      h0 <= text_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/rtdf_cell.sv
// ----------------------------------------------------------------------------
// rtdf_cell: one distance slot of the trigram row
// Holds the trigram seen a fixed number of bytes back, compares it with the
// current trigram and hands it to the next slot on every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdf_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   shift,
  input  wire                   clear,
  input  wire rtdf_pkg::link_t  link_in,
  input  wire rtdf_pkg::link_t  cur,
  output rtdf_pkg::link_t       link_q,
  output logic                  match
);

  logic            valid_q;
  rtdf_pkg::gram_t gram_q;

  assign link_q = {valid_q, gram_q};

  // a new text wipes history before the compare
  assign match = valid_q && !clear && (gram_q == cur.gram);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= link_in.valid && !clear;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      gram_q <= link_in.gram;
    end
  end

endmodule

`default_nettype wire

### rtl/repeated_trigram_distance_finder.sv
// ----------------------------------------------------------------------------
// repeated_trigram_distance_finder: Kasiski trigram distance search
// Streams ciphertext bytes and reports, per byte, the trigram it completes,
// its start index and a mask of equal trigrams up to WINDOW bytes back.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, sustained, and gives one result beat per
// byte in the cycle after its acceptance. A row of WINDOW cells holds the
// trigrams at distances 1..WINDOW; every cell compares its trigram with the
// current one in parallel and passes it one slot down on each beat, so the
// rate is set by that single compare stage. Results sit in one output
// register; in_ready is high whenever that register is empty or being read,
// so the input keeps flowing as long as the output side takes results.
// No clearing pass is needed after reset. Setting new_text on a byte starts
// a new text: history and byte count are dropped before that byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module repeated_trigram_distance_finder #(
  parameter int WINDOW = rtdf_pkg::WINDOW_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire rtdf_pkg::byte_t   text_byte,
  input  wire                    new_text,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   trigram_valid,
  output rtdf_pkg::gram_t        trigram_value,
  output rtdf_pkg::count_t       trigram_start,
  output rtdf_pkg::mask_t        match_mask
);

  logic               accept;
  rtdf_pkg::link_t    cur;
  rtdf_pkg::count_t   start;
  rtdf_pkg::link_t    chain [WINDOW];
  logic [WINDOW-1:0]  match_vec;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rtdf_head u_head (
    .clk       (clk),
    .rst       (rst),
    .shift     (accept),
    .text_byte (text_byte),
    .new_text  (new_text),
    .cur       (cur),
    .start     (start)
  );

  // cell d holds the trigram starting d+1 bytes back
  for (genvar d = 0; d < WINDOW; d++) begin : g_cell
    if (d == 0) begin : g_first
      rtdf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept),
        .clear   (new_text),
        .link_in (cur),
        .cur     (cur),
        .link_q  (chain[d]),
        .match   (match_vec[d])
      );
    end else begin : g_rest
      rtdf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept),
        .clear   (new_text),
        .link_in (chain[d-1]),
        .cur     (cur),
        .link_q  (chain[d]),
        .match   (match_vec[d])
      );
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigram_valid <= cur.valid;
      trigram_value <= cur.gram;
      trigram_start <= start;
      match_mask    <= rtdf_pkg::mask_t'(match_vec);
    end
  end

endmodule

`default_nettype wire

### rtl/rtdf_checker.sv
// ----------------------------------------------------------------------------
// rtdf_checker: port-level checks for the trigram distance finder
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdf_checker #(
  parameter int WINDOW = rtdf_pkg::WINDOW_DEF
) (
  input wire                    clk,
  input wire                    rst,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire                    new_text,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire                    trigram_valid,
  input wire rtdf_pkg::gram_t   trigram_value,
  input wire rtdf_pkg::count_t  trigram_start,
  input wire rtdf_pkg::mask_t   match_mask
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trigram_valid) &&
      $stable(trigram_value) && $stable(trigram_start) && $stable(match_mask))
    else $error("result beat changed while stalled");

  // an empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // first byte of a text yields a short-text result next cycle
  a_new_text: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && new_text |=> out_valid && !trigram_valid)
    else $error("new text did not give a short-text result");

  // short-text results carry all-zero fields
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trigram_valid |->
      trigram_value == '0 && trigram_start == '0 && match_mask == '0)
    else $error("short-text result has nonzero fields");

  // no match beyond the window
  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_mask >> WINDOW) == '0)
    else $error("match bit beyond window");

endmodule

bind repeated_trigram_distance_finder rtdf_checker #(.WINDOW(WINDOW)) u_rtdf_checker (.*);

`default_nettype wire

### tb/sv/tb_repeated_trigram_distance_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeated_trigram_distance_finder: self-checking bench for the trigram
// distance finder
// Streams short and long texts (periodic, two-symbol and noise content)
// through the byte channel and checks every result beat against a local
// trigram history model, across phases of source idling, sink stalls and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_repeated_trigram_distance_finder;

  localparam int HIST_DEPTH   = rtdf_pkg::WINDOW_DEF + 2;
  localparam int RANDOM_BYTES = 500;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 1000;

  typedef enum int {
    PH_STEADY,
    PH_BACKPRESSURE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH_IDLE,
    PH_COUNT
  } traffic_phase_t;

  typedef struct {
    rtdf_pkg::byte_t value;
    logic            fresh;
  } text_beat_t;

  typedef struct {
    logic             valid;
    rtdf_pkg::gram_t  gram;
    rtdf_pkg::count_t start;
    rtdf_pkg::mask_t  mask;
  } trigram_report_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  rtdf_pkg::byte_t  text_byte = '0;
  logic             new_text  = 1'b0;
  logic             out_ready = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic             trigram_valid;
  rtdf_pkg::gram_t  trigram_value;
  rtdf_pkg::count_t trigram_start;
  rtdf_pkg::mask_t  match_mask;

  traffic_phase_t  traffic_phase = PH_STEADY;
  text_beat_t      text_queue[$];
  trigram_report_t report_queue[$];
  int              beats_sent  = 0;
  int              hold_count  = 0;
  int              idle_cycles = 0;
  int              error_count = 0;

  // model state: recent bytes of the current text, newest at index 0
  rtdf_pkg::byte_t  hist[HIST_DEPTH];
  rtdf_pkg::count_t text_count;

  repeated_trigram_distance_finder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .new_text      (new_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigram_valid (trigram_valid),
    .trigram_value (trigram_value),
    .trigram_start (trigram_start),
    .match_mask    (match_mask)
  );

  always #1 clk = ~clk;

  // Append one byte beat to the pending queue
  task automatic queue_text(input rtdf_pkg::byte_t value, input logic fresh);
    text_beat_t item;
    item.value = value;
    item.fresh = fresh;
    text_queue = {text_queue, item};
  endtask

  // Take one byte into the history and work out the trigram report it causes
  task automatic take_text_byte(input rtdf_pkg::byte_t b, input logic fresh,
                                output trigram_report_t rep);
    rtdf_pkg::gram_t earlier_gram;
    rep = '{valid: 1'b0, gram: '0, start: '0, mask: '0};
    if (fresh) begin
      foreach (hist[i]) hist[i] = '0;
      text_count = '0;
    end
    if (text_count != rtdf_pkg::COUNT_MAX) text_count++;
    if (text_count >= rtdf_pkg::count_t'(rtdf_pkg::MIN_BYTES)) begin
      rep.valid = 1'b1;
      rep.gram  = {hist[1], hist[0], b};
      rep.start = (text_count == rtdf_pkg::COUNT_MAX) ? rtdf_pkg::COUNT_MAX
                : text_count - rtdf_pkg::count_t'(rtdf_pkg::MIN_BYTES);
      // earlier trigrams only count where they start inside this text
      for (int d = 1; d <= rtdf_pkg::WINDOW_DEF; d++) begin
        if (text_count < rtdf_pkg::count_t'(rtdf_pkg::MIN_BYTES + d)) break;
        earlier_gram = {hist[d + 1], hist[d], hist[d - 1]};
        if (earlier_gram == rep.gram) rep.mask[d - 1] = 1'b1;
      end
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = b;
  endtask

  // Byte driver: next beat from the queue, with random gaps per phase
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (text_queue.size() > 0 &&
          !(traffic_phase == PH_SRC_IDLE  && $urandom_range(0, 99) < 81) &&
          !(traffic_phase == PH_BOTH_IDLE && $urandom_range(0, 99) < 28)) begin
        text_byte <= text_queue[0].value;
        new_text  <= text_queue[0].fresh;
        in_valid  <= 1'b1;
        void'(text_queue.pop_front());
        beats_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls per phase, one long hold-off during backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case (traffic_phase)
        PH_BACKPRESSURE: begin
          if (hold_count < HOLD_CYCLES) begin
            out_ready <= 1'b0;
            hold_count++;
          end else begin
            out_ready <= 1'b1;
          end
        end
        PH_SINK_STALL: out_ready <= ($urandom_range(0, 99) >= 81);
        PH_BOTH_IDLE:  out_ready <= ($urandom_range(0, 99) >= 28);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  // Monitor: predict on accepted bytes, check accepted results in order
  always @(posedge clk) begin
    trigram_report_t rep;
    if (rst) begin
      foreach (hist[i]) hist[i] = '0;
      text_count = '0;
    end else begin
      if (in_valid && in_ready) begin
        take_text_byte(text_byte, new_text, rep);
        report_queue = {report_queue, rep};
      end
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          $error("result beat with no byte pending");
          error_count++;
        end else begin
          rep = report_queue.pop_front();
          if (trigram_valid !== rep.valid) begin
            $error("trigram_valid: expected %0d, got %0d", rep.valid, trigram_valid);
            error_count++;
          end
          if (trigram_value !== rep.gram) begin
            $error("trigram_value: expected %h, got %h", rep.gram, trigram_value);
            error_count++;
          end
          if (trigram_start !== rep.start) begin
            $error("trigram_start: expected %0d, got %0d", rep.start, trigram_start);
            error_count++;
          end
          if (match_mask !== rep.mask) begin
            $error("match_mask: expected %h, got %h", rep.mask, match_mask);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("repeated_trigram_distance_finder verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int              total;
    int              kind;
    int              len;
    int              period;
    rtdf_pkg::byte_t sym_a;
    rtdf_pkg::byte_t sym_b;
    rtdf_pkg::byte_t pattern[rtdf_pkg::WINDOW_DEF];
    text_beat_t      beat;

    // text right after reset without a start flag, then single-byte text
    queue_text(8'h80, 1'b0);
    queue_text(8'h01, 1'b0);
    queue_text(8'h41, 1'b1);
    // all-zero text: cleared history must not fake matches
    for (int i = 0; i < 5; i++) queue_text(8'h00, i == 0);
    // all-ones text
    for (int i = 0; i < 4; i++) queue_text(8'hFF, i == 0);
    // period-three text, then continued without a new start
    foreach (pattern[i]) pattern[i] = '0;
    pattern[0] = 8'h12;
    pattern[1] = 8'h34;
    pattern[2] = 8'h56;
    for (int i = 0; i < 7; i++) queue_text(pattern[i % 3], i == 0);
    queue_text(8'hA5, 1'b0);
    queue_text(8'h5A, 1'b0);

    // random texts, mostly repetitive so that masks fill up
    total = text_queue.size() + RANDOM_BYTES;
    while (text_queue.size() < total) begin
      kind  = $urandom_range(0, 9);
      sym_a = rtdf_pkg::byte_t'($urandom);
      sym_b = rtdf_pkg::byte_t'($urandom);
      case (kind)
        0:       len = $urandom_range(1, 3);
        1, 2, 3: begin
          period = ($urandom_range(0, 3) == 0)
                 ? $urandom_range(rtdf_pkg::WINDOW_DEF - 2, rtdf_pkg::WINDOW_DEF)
                 : $urandom_range(1, 16);
          len = period + $urandom_range(3, 70);
          for (int i = 0; i < period; i++) pattern[i] = rtdf_pkg::byte_t'($urandom);
        end
        4, 5, 6: len = $urandom_range(5, 60);
        7, 8:    len = $urandom_range(3, 30);
        default: len = $urandom_range(1, 20);
      endcase
      for (int i = 0; i < len; i++) begin
        case (kind)
          1, 2, 3: beat.value = ($urandom_range(0, 19) == 0) ? rtdf_pkg::byte_t'($urandom)
                                                             : pattern[i % period];
          4, 5, 6, 9: beat.value = $urandom_range(0, 1) ? sym_a : sym_b;
          default: beat.value = rtdf_pkg::byte_t'($urandom);
        endcase
        // continuation texts keep the history of the text before them
        beat.fresh = (i == 0) && (kind != 9);
        text_queue = {text_queue, beat};
      end
    end
    total = text_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // traffic phases, each over an equal share of the bytes
    for (int k = 0; k < PH_COUNT; k++) begin
      traffic_phase <= traffic_phase_t'(k);
      while (beats_sent < (total * (k + 1)) / PH_COUNT) @(posedge clk);
    end

    while (text_queue.size() > 0 || in_valid || report_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("repeated_trigram_distance_finder verification clean");
    end else begin
      $display("repeated_trigram_distance_finder verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
